/* hdl/hbf_pkg.sv */
// ----------------------------------------------------------------------------
// hbf_pkg: shared constants and types for the heart rate filter
// Field widths, ring sizing, register indexes, reset values and the
// request/response structs of the shared divider.
// ----------------------------------------------------------------------------
package hbf_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int SAMPLE_BITS = 12;
    localparam int RATE_W      = 8;
    localparam int TICK_W      = 16;
    localparam int THR_W       = 12;
    localparam int RING_DEPTH  = 5;

    localparam int IDX_W       = $clog2(RING_DEPTH);
    localparam int CNT_W       = $clog2(RING_DEPTH + 1);
    localparam int SUM_W       = $clog2(RING_DEPTH * 255 + 1);

    localparam int DIV_W       = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MINUTE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE         = 2'd3;

    // register reset values
    localparam logic [THR_W-1:0]  RST_LEVEL_THRESHOLD  = 12'd1862;
    localparam logic [TICK_W-1:0] RST_TICKS_PER_MINUTE = 16'd60000;
    localparam logic [RATE_W-1:0] RST_MIN_RATE         = 8'd30;
    localparam logic [RATE_W-1:0] RST_MAX_RATE         = 8'd200;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } hbf_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } hbf_div_rsp_t;

endpackage

/* hdl/hbf_if.sv */
// ----------------------------------------------------------------------------
// hbf_if: stream channels of the heart rate filter
// One channel carries ADC samples in, the other filtered rates out.
// ----------------------------------------------------------------------------
interface hbf_sample_if;
    logic                          valid;
    logic                          ready;
    logic [hbf_pkg::SAMPLE_W-1:0]  adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface hbf_rate_if;
    logic                          valid;
    logic                          ready;
    logic [hbf_pkg::RATE_W-1:0]    filtered_rate;

    modport source (output valid, output filtered_rate, input ready);
    modport sink   (input valid, input filtered_rate, output ready);
endinterface

/* hdl/hbf_div.sv */
// ----------------------------------------------------------------------------
// hbf_div: shared restoring divider
// One quotient bit per cycle; a start beat loads the operands and a done
// pulse marks the quotient valid once the last bit is in.
// ----------------------------------------------------------------------------
module hbf_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hbf_pkg::hbf_div_req_t req,
    output hbf_pkg::hbf_div_rsp_t rsp
);
    import hbf_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     divisor_reg;
    logic [DIV_W+1:0]     trial;

    // trial subtract of the shifted partial remainder
    assign trial = {1'b0, rem_reg, quo_reg[DIV_W-1]} - {2'b00, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (!trial[DIV_W+1])
            begin
                rem_reg <= trial[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
        else if (req.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* hdl/heart_rate_bpm_filter_unit.sv */
// ----------------------------------------------------------------------------
// heart_rate_bpm_filter_unit: pulse rate with trimmed-mean filter
// A sample that closes no edge pair, or closes one with a zero interval, keeps
// ready high. A closing edge starts a divide; the result beat follows it with
// fewer than three ring entries, and otherwise follows a ring scan and a second
// divide for the mean. An out-of-range rate holds ready low until its divide is
// done; after a result, ready returns the cycle after it is taken.
// Reset clears the tick counter, edge state, ring position and registers;
// ring contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module heart_rate_bpm_filter_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    hbf_sample_if.sink                       samples,
    hbf_rate_if.source                       rates,
    input  logic                             cfg_we,
    input  logic [hbf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hbf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_RATE,
        ST_SCAN,
        ST_TRIM,
        ST_DIV_MEAN,
        ST_OUT
    } state_t;

    // configuration registers
    logic [THR_W-1:0]  threshold_reg;
    logic [TICK_W-1:0] tpm_reg;
    logic [RATE_W-1:0] min_rate_reg;
    logic [RATE_W-1:0] max_rate_reg;

    // sequencer state and edge tracking
    state_t            state_reg;
    logic              prev_high_reg;
    logic              armed_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] start_tick_reg;

    // ring and filter working registers
    logic [RATE_W-1:0] ring_reg [RING_DEPTH];
    logic [IDX_W-1:0]  wp_reg;
    logic              full_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [RATE_W-1:0] lo_reg;
    logic [RATE_W-1:0] hi_reg;

    // output register and divider request
    logic              out_valid_reg;
    logic [RATE_W-1:0] rate_reg;
    hbf_div_req_t      div_req_reg;
    hbf_div_rsp_t      div_rsp;

    // combinational helpers
    logic              accept;
    logic [TICK_W-1:0] tick_next;
    logic              high;
    logic              rising;
    logic [TICK_W-1:0] delta;
    logic              in_range;
    logic              push;
    logic [IDX_W-1:0]  wp_next;
    logic              full_next;
    logic [CNT_W-1:0]  count_next;
    logic [RATE_W-1:0] scan_val;
    logic              scan_last;
    logic [SUM_W-1:0]  trimmed;
    logic              div_start;

    hbf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    assign samples.ready       = (state_reg == ST_IDLE);
    assign rates.valid         = out_valid_reg;
    assign rates.filtered_rate = rate_reg;

    assign accept    = samples.valid && samples.ready;
    assign tick_next = tick_reg + TICK_W'(1);
    assign high      = (samples.adc_sample & SAMPLE_MASK) > threshold_reg;
    assign rising    = high && !prev_high_reg;
    assign delta     = tick_next - start_tick_reg;

    // start a divide on a closing edge with a non-zero interval, or for the mean
    assign div_start = ((state_reg == ST_IDLE) && accept && rising && armed_reg
                        && (delta != '0))
                    || (state_reg == ST_TRIM);

    // range check is taken on the full 16-bit quotient
    assign in_range  = (div_rsp.quotient >= DIV_W'(min_rate_reg))
                    && (div_rsp.quotient <= DIV_W'(max_rate_reg));
    assign push      = (state_reg == ST_DIV_RATE) && div_rsp.done && in_range;

    always_comb
    begin
        if (wp_reg == IDX_W'(RING_DEPTH - 1))
        begin
            wp_next   = '0;
            full_next = 1'b1;
        end
        else
        begin
            wp_next   = wp_reg + IDX_W'(1);
            full_next = full_reg;
        end
        count_next = full_next ? CNT_W'(RING_DEPTH) : CNT_W'(wp_next);
    end

    assign scan_val  = ring_reg[idx_reg];
    assign scan_last = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));
    assign trimmed   = sum_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg);

    // configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= RST_LEVEL_THRESHOLD;
            tpm_reg       <= RST_TICKS_PER_MINUTE;
            min_rate_reg  <= RST_MIN_RATE;
            max_rate_reg  <= RST_MAX_RATE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEVEL_THRESHOLD:  threshold_reg <= cfg_data[THR_W-1:0];
                CFG_TICKS_PER_MINUTE: tpm_reg       <= cfg_data[TICK_W-1:0];
                CFG_MIN_RATE:         min_rate_reg  <= cfg_data[RATE_W-1:0];
                CFG_MAX_RATE:         max_rate_reg  <= cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // ring storage: written once per accepted rate, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ring_reg[wp_reg] <= div_rsp.quotient[RATE_W-1:0];
        end
    end

    // datapath working registers of the scan
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
            lo_reg  <= '1;
            hi_reg  <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            sum_reg <= sum_reg + SUM_W'(scan_val);
            if (scan_val < lo_reg)
            begin
                lo_reg <= scan_val;
            end
            if (scan_val > hi_reg)
            begin
                hi_reg <= scan_val;
            end
        end
    end

    // sequencer: state, edge tracking, ring position and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_high_reg  <= 1'b0;
            armed_reg      <= 1'b0;
            tick_reg       <= '0;
            start_tick_reg <= '0;
            wp_reg         <= '0;
            full_reg       <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            rate_reg       <= '0;
            div_req_reg    <= '0;
        end
        else
        begin
            div_req_reg.start <= div_start;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        tick_reg      <= tick_next;
                        prev_high_reg <= high;
                        if (rising)
                        begin
                            if (!armed_reg)
                            begin
                                // first edge of a pair: hold its tick
                                armed_reg      <= 1'b1;
                                start_tick_reg <= tick_next;
                            end
                            else
                            begin
                                // second edge: drop a zero interval, else divide
                                armed_reg <= 1'b0;
                                if (delta != '0)
                                begin
                                    div_req_reg.dividend <= tpm_reg;
                                    div_req_reg.divisor  <= delta;
                                    state_reg            <= ST_DIV_RATE;
                                end
                            end
                        end
                    end
                end

                ST_DIV_RATE:
                begin
                    if (div_rsp.done)
                    begin
                        if (!in_range)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            wp_reg    <= wp_next;
                            full_reg  <= full_next;
                            count_reg <= count_next;
                            if (count_next < CNT_W'(3))
                            begin
                                // short ring: the newest rate passes straight out
                                rate_reg      <= div_rsp.quotient[RATE_W-1:0];
                                out_valid_reg <= 1'b1;
                                state_reg     <= ST_OUT;
                            end
                            else
                            begin
                                state_reg <= ST_SCAN;
                            end
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (scan_last)
                    begin
                        state_reg <= ST_TRIM;
                    end
                end

                ST_TRIM:
                begin
                    // drop one minimum and one maximum, then average
                    div_req_reg.dividend <= DIV_W'(trimmed);
                    div_req_reg.divisor  <= DIV_W'(count_reg - CNT_W'(2));
                    state_reg            <= ST_DIV_MEAN;
                end

                ST_DIV_MEAN:
                begin
                    if (div_rsp.done)
                    begin
                        rate_reg      <= div_rsp.quotient[RATE_W-1:0];
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                end

                ST_OUT:
                begin
                    // hold the beat until the sink takes it
                    if (rates.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for heart_rate_bpm_filter_unit
// Streams ADC samples as pulse trains against a series of register
// settings and checks every filtered rate beat against a cycle-free
// model of the edge pairing, the rate divide and the trimmed-mean ring.
// ----------------------------------------------------------------------------
module tb;

    import hbf_pkg::*;

    localparam int SETTLE_CYCLES = 40;     // longer than a closing edge that yields no rate
    localparam int RANDOM_ITEMS  = 600;
    localparam int MIN_RATES     = 36;
    localparam int MAX_PHASES    = 60;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Channels and the block
    // ------------------------------------------------------------------
    hbf_sample_if samples_ch ();
    hbf_rate_if   rates_ch ();

    logic                  drv_valid   = 1'b0;
    logic [SAMPLE_W-1:0]   drv_sample  = '0;
    logic                  rate_ready  = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    assign samples_ch.valid      = drv_valid;
    assign samples_ch.adc_sample = drv_sample;
    assign rates_ch.ready        = rate_ready;

    heart_rate_bpm_filter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_ch),
        .rates     (rates_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Rate model: register copies and detector/ring state
    // ------------------------------------------------------------------
    logic [THR_W-1:0]  cur_threshold = RST_LEVEL_THRESHOLD;
    logic [TICK_W-1:0] cur_tpm       = RST_TICKS_PER_MINUTE;
    logic [RATE_W-1:0] cur_min       = RST_MIN_RATE;
    logic [RATE_W-1:0] cur_max       = RST_MAX_RATE;

    logic              was_high   = 1'b0;
    logic [TICK_W-1:0] tick_now   = '0;
    logic              pair_armed = 1'b0;
    logic [TICK_W-1:0] pair_start = '0;
    logic [RATE_W-1:0] rate_hist [RING_DEPTH];
    int unsigned       hist_wr    = 0;
    logic              hist_full  = 1'b0;

    logic [SAMPLE_W-1:0] sample_backlog [$];   // samples waiting for the driver
    logic [RATE_W-1:0]   expected_rates [$];   // filtered rates still owed by the block
    int                  rates_predicted = 0;
    int                  mismatch_count  = 0;
    int                  random_items    = 0;

    // Advance one tick and return the filtered rate if this sample closes an
    // edge pair whose rate falls inside the accepted window.
    function automatic void predict_rate(input logic [SAMPLE_W-1:0] sample,
                                         output logic emits,
                                         output logic [RATE_W-1:0] rate);
        logic              now_high;
        logic              rising;
        logic [TICK_W-1:0] interval;
        logic [TICK_W-1:0] quotient;
        int unsigned       count;
        int unsigned       sum;
        int unsigned       lo;
        int unsigned       hi;
        emits    = 1'b0;
        rate     = '0;
        tick_now = tick_now + 1'b1;
        now_high = ({4'd0, cur_threshold} < {4'd0, sample & SAMPLE_MASK});
        rising   = now_high && !was_high;
        was_high = now_high;
        if (!rising)
            return;
        // first edge of a pair only records where it fell
        if (!pair_armed) begin
            pair_armed = 1'b1;
            pair_start = tick_now;
            return;
        end
        pair_armed = 1'b0;
        interval   = tick_now - pair_start;
        // a pair a whole counter span apart gives nothing
        if (interval == '0)
            return;
        quotient = cur_tpm / interval;
        // window check uses the full 16-bit quotient
        if (quotient < {8'd0, cur_min} || quotient > {8'd0, cur_max})
            return;
        rate_hist[hist_wr] = quotient[RATE_W-1:0];
        hist_wr++;
        if (hist_wr == RING_DEPTH) begin
            hist_wr   = 0;
            hist_full = 1'b1;
        end
        count = hist_full ? RING_DEPTH : hist_wr;
        emits = 1'b1;
        if (count < 3) begin
            rate = rate_hist[(hist_wr == 0) ? RING_DEPTH - 1 : hist_wr - 1];
            return;
        end
        sum = 0;
        lo  = 255;
        hi  = 0;
        for (int i = 0; i < count; i++) begin
            sum += rate_hist[i];
            if (rate_hist[i] < lo)
                lo = rate_hist[i];
            if (rate_hist[i] > hi)
                hi = rate_hist[i];
        end
        rate = RATE_W'((sum - lo - hi) / (count - 2));
    endfunction

    // ------------------------------------------------------------------
    // Driver: feed the sample channel in bursts with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (drv_valid && !samples_ch.ready)
        begin
            // hold the beat until the block takes it
        end
        else if (gap_left != 0)
        begin
            gap_left--;
            drv_valid <= 1'b0;
        end
        else if (sample_backlog.size() != 0)
        begin
            drv_valid  <= 1'b1;
            drv_sample <= sample_backlog.pop_front();
            if (burst_left <= 1)
            begin
                // one burst in four runs straight into the next
                burst_left = $urandom_range(32, 1);
                gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            end
            else
            begin
                burst_left--;
            end
        end
        else
        begin
            drv_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: rotate a random ready pattern, renewed at the end
    // of each epoch; bit 0 is forced so no stall outlasts the pattern, and one
    // epoch in four never stalls at all
    // ------------------------------------------------------------------
    logic [15:0] stall_pattern = 16'hFFFF;
    int          epoch_left    = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_ready <= 1'b0;
            epoch_left = 0;
        end
        else
        begin
            if (epoch_left == 0)
            begin
                stall_pattern = ($urandom_range(3, 0) == 0) ? 16'hFFFF
                                                           : 16'($urandom()) | 16'h0001;
                epoch_left    = 48;
            end
            else
            begin
                stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
                epoch_left--;
            end
            rate_ready <= stall_pattern[0];
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each rate beat against the oldest expectation, then
    // run the model on any sample beat taken at the same edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        logic              emits;
        logic [RATE_W-1:0] rate;
        logic [RATE_W-1:0] want;
        if (rst_n)
        begin
            if (rates_ch.valid && rates_ch.ready)
            begin
                if (expected_rates.size() == 0)
                begin
                    $display("%0t: filtered_rate expected none, actual %0d",
                             $time, rates_ch.filtered_rate);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_rates.pop_front();
                    if (rates_ch.filtered_rate !== want)
                    begin
                        $display("%0t: filtered_rate expected %0d, actual %0d",
                                 $time, want, rates_ch.filtered_rate);
                        mismatch_count++;
                    end
                end
            end
            if (samples_ch.valid && samples_ch.ready)
            begin
                predict_rate(samples_ch.adc_sample, emits, rate);
                if (emits)
                begin
                    expected_rates.push_back(rate);
                    rates_predicted++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Write one register with the block idle and mirror it into the model.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_LEVEL_THRESHOLD:  cur_threshold = THR_W'(val);
            CFG_TICKS_PER_MINUTE: cur_tpm       = TICK_W'(val);
            CFG_MIN_RATE:         cur_min       = RATE_W'(val);
            CFG_MAX_RATE:         cur_max       = RATE_W'(val);
            default: ;
        endcase
    endtask

    task automatic apply_config(input int unsigned thr, input int unsigned tpm,
                                input int unsigned lo, input int unsigned hi);
        set_reg(CFG_LEVEL_THRESHOLD, thr);
        set_reg(CFG_TICKS_PER_MINUTE, tpm);
        set_reg(CFG_MIN_RATE, lo);
        set_reg(CFG_MAX_RATE, hi);
    endtask

    function automatic logic [SAMPLE_W-1:0] quiet_level();
        return SAMPLE_W'($urandom_range(cur_threshold, 0));
    endfunction

    function automatic logic [SAMPLE_W-1:0] peak_level();
        // nothing exceeds a full-scale threshold: any code stays quiet
        if (cur_threshold == SAMPLE_MASK)
            return SAMPLE_W'($urandom_range(SAMPLE_MASK, 0));
        return SAMPLE_W'($urandom_range(SAMPLE_MASK, cur_threshold + 1));
    endfunction

    // Quiet run then a peak run; the rising edge lands on the first peak.
    task automatic add_pulse(input int lows, input int highs);
        repeat (lows)
            sample_backlog.push_back(quiet_level());
        repeat (highs)
            sample_backlog.push_back(peak_level());
    endtask

    // Let the driver empty its backlog and every owed rate arrive, then
    // allow for a closing edge that produced nothing but is still busy.
    task automatic drain();
        while (sample_backlog.size() != 0 || drv_valid || expected_rates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int phase_no;
        int pulses;
        int level;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: a sample equal to the threshold is quiet, and a
        // two-tick pair gives a rate far above the window.
        sample_backlog.push_back(SAMPLE_W'(RST_LEVEL_THRESHOLD));
        sample_backlog.push_back(SAMPLE_W'(RST_LEVEL_THRESHOLD + 1));
        sample_backlog.push_back('0);
        sample_backlog.push_back(SAMPLE_MASK);
        drain();

        // Window edges: 600/3 sits on the maximum, 600/6 on the minimum,
        // 600/2 is just above; the first two also fill the ring's short mode.
        apply_config(2048, 600, 100, 200);
        add_pulse(1, 1);
        add_pulse(2, 1);
        add_pulse(1, 1);
        add_pulse(5, 1);
        add_pulse(1, 1);
        add_pulse(1, 1);
        drain();

        // Random pulse trains; the first phases sweep the register extremes.
        phase_no = 0;
        while ((random_items < RANDOM_ITEMS || rates_predicted < MIN_RATES)
               && phase_no < MAX_PHASES)
        begin
            case ((phase_no < 7) ? phase_no : 7)
                0: apply_config(0, 65535, 0, 255);
                1: apply_config(SAMPLE_MASK, 1, 0, 0);
                2: apply_config($urandom_range(4094, 1), 1, 0, 255);
                3: apply_config($urandom_range(4094, 1), 0, 0, $urandom_range(255, 0));
                4: apply_config($urandom_range(4094, 1), 600, 255, 0);
                5:
                begin
                    level = $urandom_range(100, 25);
                    apply_config($urandom_range(4094, 1), 600, level, level);
                end
                6: apply_config($urandom_range(4094, 1), 2000, 0, 255);
                default:
                    apply_config($urandom_range(4094, 1), $urandom_range(1500, 200),
                                 $urandom_range(60, 0), $urandom_range(255, 120));
            endcase
            pulses = $urandom_range(30, 10);
            repeat (pulses)
            begin
                if ($urandom_range(7, 0) == 0)
                begin
                    // chatter: raw codes with no pulse shape
                    repeat ($urandom_range(6, 1))
                        sample_backlog.push_back(SAMPLE_W'($urandom_range(SAMPLE_MASK, 0)));
                end
                else if ($urandom_range(5, 0) == 0)
                begin
                    add_pulse($urandom_range(40, 7), $urandom_range(6, 1));
                end
                else
                begin
                    add_pulse($urandom_range(6, 1), $urandom_range(6, 1));
                end
            end
            random_items += sample_backlog.size();
            drain();
            phase_no++;
        end

        if (mismatch_count == 0 && expected_rates.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Drop the run if the block stops answering.
    initial
    begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
